// ----- hdl/q2r_pkg.sv -----
// Shared types and constants for the quaternion to rotation matrix block.
// No dependencies; used by q2r_div_stage and quaternion_to_rotation_matrix.
`timescale 1ns / 1ps

package q2r_pkg;

  localparam int QW     = 16;          // field width
  localparam int Q_ONE  = 16384;       // 1.0 in Q1.14
  localparam int NW     = 33;          // norm w^2+x^2+y^2+z^2, up to 2^32
  localparam int DW     = NW + 1;      // divisor 2N
  localparam int QB     = 15;          // quotient bits, 0..16384
  localparam int RW     = NW + QB + 1; // dividend mag*2^15 + N
  localparam int N_ENT  = 9;           // matrix entries

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } in_t;

  typedef struct packed {
    logic signed [QW-1:0] r00;
    logic signed [QW-1:0] r01;
    logic signed [QW-1:0] r02;
    logic signed [QW-1:0] r10;
    logic signed [QW-1:0] r11;
    logic signed [QW-1:0] r12;
    logic signed [QW-1:0] r20;
    logic signed [QW-1:0] r21;
    logic signed [QW-1:0] r22;
    logic                 zero_quat;
  } out_t;

  // state carried through the divider pipeline
  typedef struct packed {
    logic                        vld;
    logic                        zero;
    logic [N_ENT-1:0]            neg;
    logic [N_ENT-1:0][RW-1:0]    rem;
    logic [N_ENT-1:0][QB-1:0]    quo;
    logic [DW-1:0]               den;
  } div_t;

endpackage

// ----- hdl/q2r_div_stage.sv -----
// One restoring-division stage: resolves quotient bit SHIFT for all nine lanes.
// Depends on q2r_pkg.
`timescale 1ns / 1ps

module q2r_div_stage import q2r_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  div_t d_in,
  output div_t d_out
);

  div_t         d_nxt;
  div_t         d_r;
  logic [RW-1:0] dsh;
  logic [RW:0]   trial [N_ENT];

  always_comb begin
    d_nxt = d_in;
    dsh   = RW'(d_in.den) << SHIFT;
    for (int i = 0; i < N_ENT; i++) begin
      trial[i] = {1'b0, d_in.rem[i]} - {1'b0, dsh};
      if (!trial[i][RW]) begin
        d_nxt.rem[i]        = trial[i][RW-1:0];
        d_nxt.quo[i][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// ----- hdl/quaternion_to_rotation_matrix.sv -----
// An accepted start passes through the product, norm, divider and output stages to the out_valid strobe.
// Throughput: one transaction per cycle; busy is high only while in reset and
// the cycle after, so back-to-back starts stream through the pipeline.
// Reset (rst_n, synchronous, active low) clears all valid bits in the pipeline.
// Results cannot be stalled: each is shown for exactly one cycle on out_valid.
// Depends on q2r_pkg and q2r_div_stage.
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix import q2r_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_quat,
  output logic out_valid,
  output out_t out_mat
);

  localparam int LAT = QB + 3;

  logic ready_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= 1'b1;
    end
  end

  assign busy   = ~ready_r;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------
  // Stage 1: the ten 16x16 products.
  // ---------------------------------------------------------------
  logic                 s1_vld_r;
  logic signed [31:0]   ww_r, xx_r, yy_r, zz_r;
  logic signed [31:0]   xy_r, zw_r, xz_r, yw_r, yz_r, xw_r;

  always_ff @(posedge clk) begin
    ww_r <= in_quat.quat_w * in_quat.quat_w;
    xx_r <= in_quat.quat_x * in_quat.quat_x;
    yy_r <= in_quat.quat_y * in_quat.quat_y;
    zz_r <= in_quat.quat_z * in_quat.quat_z;
    xy_r <= in_quat.quat_x * in_quat.quat_y;
    zw_r <= in_quat.quat_z * in_quat.quat_w;
    xz_r <= in_quat.quat_x * in_quat.quat_z;
    yw_r <= in_quat.quat_y * in_quat.quat_w;
    yz_r <= in_quat.quat_y * in_quat.quat_z;
    xw_r <= in_quat.quat_x * in_quat.quat_w;
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: norm N, the nine numerators, split into sign and
  // magnitude. Dividend is mag*2^15 + N over divisor 2N, which gives
  // round-half-away of mag*2^14/N as a floor.
  // ---------------------------------------------------------------
  logic [NW-1:0]               norm;
  logic signed [DW-1:0]        num [N_ENT];
  logic [NW-1:0]               mag [N_ENT];
  div_t                        s2_nxt;
  div_t                        s2_r;
  div_t                        pipe [QB+1];

  function automatic logic signed [DW-1:0] sx(input logic signed [31:0] v);
    return DW'(v);
  endfunction

  always_comb begin
    norm = NW'(unsigned'(ww_r)) + NW'(unsigned'(xx_r))
         + NW'(unsigned'(yy_r)) + NW'(unsigned'(zz_r));
    num[0] = signed'({1'b0, norm}) - ((sx(yy_r) + sx(zz_r)) <<< 1);
    num[1] = (sx(xy_r) - sx(zw_r)) <<< 1;
    num[2] = (sx(xz_r) + sx(yw_r)) <<< 1;
    num[3] = (sx(xy_r) + sx(zw_r)) <<< 1;
    num[4] = signed'({1'b0, norm}) - ((sx(xx_r) + sx(zz_r)) <<< 1);
    num[5] = (sx(yz_r) - sx(xw_r)) <<< 1;
    num[6] = (sx(xz_r) - sx(yw_r)) <<< 1;
    num[7] = (sx(yz_r) + sx(xw_r)) <<< 1;
    num[8] = signed'({1'b0, norm}) - ((sx(xx_r) + sx(yy_r)) <<< 1);

    s2_nxt      = '0;
    s2_nxt.vld  = s1_vld_r;
    s2_nxt.zero = (norm == '0);
    s2_nxt.den  = {norm, 1'b0};
    for (int i = 0; i < N_ENT; i++) begin
      s2_nxt.neg[i] = num[i][DW-1];
      mag[i]        = num[i][DW-1] ? NW'(-num[i]) : NW'(num[i]);
      s2_nxt.rem[i] = {1'b0, mag[i], {QB{1'b0}}} + RW'(norm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else begin
      s2_r <= s2_nxt;
    end
  end

  assign pipe[0] = s2_r;

  // ---------------------------------------------------------------
  // Stages 3..17: one quotient bit per stage, MSB first.
  // ---------------------------------------------------------------
  for (genvar g = 0; g < QB; g++) begin : g_div
    q2r_div_stage #(.SHIFT(QB - 1 - g)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (pipe[g]),
      .d_out (pipe[g+1])
    );
  end

  // ---------------------------------------------------------------
  // Stage 18: clamp, sign, zero-quaternion override.
  // ---------------------------------------------------------------
  div_t                 fin;
  logic [QB-1:0]        qc  [N_ENT];
  logic signed [QW-1:0] ent [N_ENT];
  out_t                 out_nxt;
  out_t                 out_r;
  logic                 out_valid_r;

  assign fin = pipe[QB];

  always_comb begin
    for (int i = 0; i < N_ENT; i++) begin
      qc[i]  = (fin.quo[i] > QB'(Q_ONE)) ? QB'(Q_ONE) : fin.quo[i];
      ent[i] = fin.neg[i] ? -signed'({1'b0, qc[i]}) : signed'({1'b0, qc[i]});
      if (fin.zero) begin
        ent[i] = (i == 0 || i == 4 || i == 8) ? QW'(Q_ONE) : '0;
      end
    end
    out_nxt.r00       = ent[0];
    out_nxt.r01       = ent[1];
    out_nxt.r02       = ent[2];
    out_nxt.r10       = ent[3];
    out_nxt.r11       = ent[4];
    out_nxt.r12       = ent[5];
    out_nxt.r20       = ent[6];
    out_nxt.r21       = ent[7];
    out_nxt.r22       = ent[8];
    out_nxt.zero_quat = fin.zero;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.vld;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mat   = out_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(accept, LAT))
    else $error("result strobe does not follow start by the pipeline latency");

  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mat.zero_quat |-> out_mat.r00 == QW'(Q_ONE) &&
      out_mat.r11 == QW'(Q_ONE) && out_mat.r22 == QW'(Q_ONE) &&
      out_mat.r01 == '0 && out_mat.r12 == '0 && out_mat.r20 == '0)
    else $error("zero quaternion did not give the identity matrix");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mat.r00 <= QW'(Q_ONE) && out_mat.r00 >= -QW'(Q_ONE) &&
      out_mat.r12 <= QW'(Q_ONE) && out_mat.r12 >= -QW'(Q_ONE))
    else $error("matrix entry outside +/-1.0");
`endif

endmodule
